/* rtl/msq_pkg.sv */
// msq_pkg: command and status types shared by the min subset xor controller
// and datapath. No dependencies.
package msq_pkg;

  typedef struct packed {
    logic load;      // latch the input item
    logic clear_wr;  // write zero to every row at the sweep address
    logic wr_lo;     // write the lower entry of a value pair
    logic wr_hi;     // write the partner entry of a value pair
    logic wr_row0;   // set the size-one entry of the pushed value
    logic cnt_inc;   // advance the sweep address
    logic query_rd;  // read all rows at the query target
    logic out_load;  // load the result register
  } msq_cmd_t;

  typedef struct packed {
    logic last;  // sweep address at its final value
    logic skip;  // pair already handled from its lower member
    logic full;  // no more positions left
  } msq_status_t;

endpackage

/* rtl/msq_dp.sv */
// msq_dp: per-size position tables, sweep address, pair update and query
// evaluation. Depends on msq_pkg.
module msq_dp #(
  parameter int VALUE_BITS    = 12,
  parameter int MAX_SUBSET    = 12,
  parameter int MAX_POSITIONS = 16384
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  msq_pkg::msq_cmd_t                      cmd_i,
  output msq_pkg::msq_status_t                   status_o,
  input  logic [VALUE_BITS-1:0]                  element_value_i,
  input  logic [$clog2(MAX_POSITIONS+1)-1:0]     query_left_i,
  input  logic [VALUE_BITS-1:0]                  query_xor_i,
  output logic [$clog2(MAX_SUBSET+1)-1:0]        min_size_o
);
  import msq_pkg::*;

  localparam int VC = 1 << VALUE_BITS;
  localparam int PW = $clog2(MAX_POSITIONS + 1);
  localparam int SW = $clog2(MAX_SUBSET + 1);

  logic [VALUE_BITS-1:0] cnt_q, val_q, target_q;
  logic [PW-1:0]         left_q, count_q;
  logic [SW-1:0]         min_size_q;
  logic [VALUE_BITS-1:0] addr_a, addr_b;
  logic [PW-1:0]         rda_q [MAX_SUBSET];
  logic [PW-1:0]         rdb_q [MAX_SUBSET];
  logic                  we    [MAX_SUBSET];
  logic [VALUE_BITS-1:0] waddr [MAX_SUBSET];
  logic [PW-1:0]         wdata [MAX_SUBSET];
  logic [SW-1:0]         size_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.wr_row0) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q    <= element_value_i;
      target_q <= query_xor_i;
      left_q   <= query_left_i;
    end
    if (cmd_i.out_load) min_size_q <= size_d;
  end

  assign addr_a = cmd_i.query_rd ? target_q : cnt_q;
  assign addr_b = cnt_q ^ val_q;

  assign status_o.last = (cnt_q == VALUE_BITS'(VC - 1));
  assign status_o.skip = (cnt_q > addr_b);
  assign status_o.full = (count_q == PW'(MAX_POSITIONS));

  always_comb begin
    for (int k = 0; k < MAX_SUBSET; k++) begin
      we[k]    = cmd_i.clear_wr;
      waddr[k] = cnt_q;
      wdata[k] = '0;
      if (k == 0) begin
        if (cmd_i.wr_row0) begin
          we[k]    = 1'b1;
          waddr[k] = val_q;
          wdata[k] = count_q + 1'b1;
        end
      end else if (cmd_i.wr_lo) begin
        // row k (size k+1) takes the later start of itself and row k-1 (size k) at the partner
        we[k]    = 1'b1;
        wdata[k] = (rdb_q[k-1] > rda_q[k]) ? rdb_q[k-1] : rda_q[k];
      end else if (cmd_i.wr_hi) begin
        we[k]    = 1'b1;
        waddr[k] = addr_b;
        wdata[k] = (rda_q[k-1] > rdb_q[k]) ? rda_q[k-1] : rdb_q[k];
      end
    end
  end

  for (genvar k = 0; k < MAX_SUBSET; k++) begin : g_row
    logic [PW-1:0] mem [VC];
    always_ff @(posedge clk_i) begin
      if (we[k]) mem[waddr[k]] <= wdata[k];
      rda_q[k] <= mem[addr_a];
      rdb_q[k] <= mem[addr_b];
    end
  end

  // smallest size whose latest start lies inside the segment
  always_comb begin
    size_d = '0;
    for (int k = MAX_SUBSET - 1; k >= 0; k--) begin
      if (rda_q[k] != '0 && rda_q[k] >= left_q) size_d = SW'(k + 1);
    end
  end

  assign min_size_o = min_size_q;

endmodule

/* rtl/msq_ctrl.sv */
// msq_ctrl: sequencer for clearing, push sweeps and queries.
// Depends on msq_pkg.
module msq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 mode_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output msq_pkg::msq_cmd_t    cmd_o,
  input  msq_pkg::msq_status_t status_i
);
  import msq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PRD, S_PWLO, S_PWHI, S_PROW0, S_QRD, S_QEV
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !(out_valid_q && out_stall_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.clear_wr = (state_q == S_CLEAR);
    cmd_o.wr_lo    = (state_q == S_PWLO);
    cmd_o.wr_hi    = (state_q == S_PWHI);
    cmd_o.wr_row0  = (state_q == S_PROW0);
    cmd_o.cnt_inc  = (state_q == S_CLEAR) || (state_q == S_PWHI) ||
                     ((state_q == S_PRD) && status_i.skip);
    // keep the read address on the target while the result waits
    cmd_o.query_rd = (state_q == S_QRD) || (state_q == S_QEV);
    cmd_o.out_load = (state_q == S_QEV) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: if (status_i.last) state_q <= S_IDLE;
        S_IDLE: begin
          if (in_valid_i) begin
            if (mode_i) state_q <= S_QRD;
            else if (!status_i.full) state_q <= S_PRD;
          end
        end
        S_PRD: begin
          if (!status_i.skip) state_q <= S_PWLO;
          else if (status_i.last) state_q <= S_PROW0;
        end
        S_PWLO: state_q <= S_PWHI;
        S_PWHI: state_q <= status_i.last ? S_PROW0 : S_PRD;
        S_PROW0: state_q <= S_IDLE;
        S_QRD: state_q <= S_QEV;
        S_QEV: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_pair_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PWLO |=> state_q == S_PWHI) else $error("pair write split");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i)) else $error("result overwritten");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_QEV)) else $error("spurious result");

endmodule

/* rtl/min_subset_xor_range_query_unit.sv */
// min_subset_xor_range_query_unit: top level joining msq_ctrl and msq_dp.
// Depends on msq_pkg, msq_ctrl, msq_dp.
//
// A push (mode 0) sweeps the 2^VALUE_BITS xor values once, taking each value
// together with its partner value ^ element: every size row is read at both
// addresses, then the lower entry of the pair and its partner entry are written,
// while a value whose pair was already handled is passed over after the read.
// The size-one entry of the pushed value is written after the sweep. A zero
// element pairs every value with itself, so no value is passed over. All size
// rows are updated in parallel, one memory per size with two read ports and one
// write port setting the pace. A push past MAX_POSITIONS is dropped. A query
// reads every size row at the query target, then returns min_size, waiting
// while an earlier result is stalled. After reset the tables are cleared over
// the whole sweep, no item taken.
module min_subset_xor_range_query_unit #(
  parameter int VALUE_BITS    = 12,
  parameter int MAX_SUBSET    = 12,
  parameter int MAX_POSITIONS = 16384
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [VALUE_BITS-1:0]              element_value_i,
  input  logic [$clog2(MAX_POSITIONS+1)-1:0] query_left_i,
  input  logic [VALUE_BITS-1:0]              query_xor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [$clog2(MAX_SUBSET+1)-1:0]    min_size_o
);
  import msq_pkg::*;

  msq_cmd_t    cmd;
  msq_status_t status;

  msq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  msq_dp #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_SUBSET    (MAX_SUBSET),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .element_value_i (element_value_i),
    .query_left_i    (query_left_i),
    .query_xor_i     (query_xor_i),
    .min_size_o      (min_size_o)
  );

endmodule
